### sv/pse_pkg.sv
package pse_pkg;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 48;
  localparam int MIN_LEN_W = 6;
  localparam int MAX_LEN   = 32;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CMP_W     = (LEN_W > MIN_LEN_W) ? LEN_W : MIN_LEN_W;

  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(4);
  localparam logic [BYTE_W-1:0]    NEWLINE_BYTE  = 8'h0A;
  localparam logic [BYTE_W-1:0]    PRINT_LO      = 8'h20;
  localparam logic [BYTE_W-1:0]    PRINT_HI      = 8'h7E;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic              end_of_range;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  string_offset;
    logic              first_of_string;
    logic              end_of_string;
    logic              last_of_step;
  } out_item_t;

endpackage

### sv/pse_cell.sv
module pse_cell
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [BYTE_W-1:0] load_data,
  input  logic              shift,
  input  logic [BYTE_W-1:0] next_data,
  output logic [BYTE_W-1:0] cell_data
);

  logic [BYTE_W-1:0] data_r;

  // a load and a shift never coincide: loads happen while collecting, shifts while releasing
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end else if (shift) begin
      data_r <= next_data;
    end
  end

  assign cell_data = data_r;

endmodule

### sv/printable_string_extractor.sv
// Printable string extractor.
// Input channel (in_valid / in_stall / in_data): one scanned byte per request with its file
// offset and an end-of-range flag. Output channel (out_valid / out_stall / out_data): string
// bytes, each tagged with the offset where its string began; a newline with end_of_string
// closes each reported string, and last_of_step marks the final result of an input byte.
// Configuration (cfg_valid / cfg_ready / cfg_data): minimum reported run length, write only
// while the block is idle; cfg_ready is always high.
// Runs shorter than the minimum are collected in a row of byte cells. When a run reaches the
// minimum, the cells shift out toward cell 0, one byte per cycle while the output is free.
// A passed byte or a newline is in the output register in the cycle after its request is
// accepted; the first byte of a release is emitted from the release state after its load.
// Bytes that are held or pass straight through are taken one per cycle while the output is
// free; a passed byte that ends the range is followed by its newline. The byte that qualifies a
// run is loaded, then the cell row drains one cell a cycle while the output is free, followed
// by a newline if it also closes the run. A non-printable byte ending a reported string emits its newline.
// New bytes are taken only when no release or newline is pending.
// Reset (rst_n low, synchronous): clears the run state and the output valid, and sets the
// minimum length to 4. The cell contents are not cleared.
// While out_stall is high with out_valid set, the output register holds, and in_stall rises
// once the next result has nowhere to go.
module printable_string_extractor
  import pse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MIN_LEN_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REL  = 2'd1;
  localparam logic [1:0] S_NL   = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [MIN_LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0]     run_length_r, run_length_nxt;
  logic                 run_qualified_r, run_qualified_nxt;
  logic [POS_W-1:0]     run_start_r, run_start_nxt;
  logic [LEN_W-1:0]     rel_cnt_r, rel_cnt_nxt;
  logic                 rel_first_r, rel_first_nxt;
  logic                 nl_pend_r, nl_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 printable;
  logic [CMP_W-1:0]     min_ext;
  logic [LEN_W-1:0]     m_eff;
  logic [LEN_W-1:0]     new_len;
  logic                 emit;
  out_item_t            emit_item;
  logic [MAX_LEN-1:0]   load_vec;
  logic                 shift;
  logic [BYTE_W-1:0]    cell_bytes [MAX_LEN];

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign printable = (in_data.data_byte >= PRINT_LO) && (in_data.data_byte <= PRINT_HI);
  assign min_ext   = CMP_W'(min_len_r);
  assign new_len   = run_length_r + LEN_W'(1);

  always_comb begin
    if (min_len_r == '0) begin
      m_eff = LEN_W'(1);
    end else if (min_ext > CMP_W'(MAX_LEN)) begin
      m_eff = LEN_W'(MAX_LEN);
    end else begin
      m_eff = LEN_W'(min_ext);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    run_length_nxt    = run_length_r;
    run_qualified_nxt = run_qualified_r;
    run_start_nxt     = run_start_r;
    rel_cnt_nxt       = rel_cnt_r;
    rel_first_nxt     = rel_first_r;
    nl_pend_nxt       = nl_pend_r;
    emit              = 1'b0;
    emit_item         = '0;
    load_vec          = '0;
    shift             = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (printable) begin
            if (run_qualified_r) begin
              // pass straight through
              emit                      = 1'b1;
              emit_item.out_byte        = in_data.data_byte;
              emit_item.string_offset   = run_start_r;
              emit_item.last_of_step    = !in_data.end_of_range;
              if (in_data.end_of_range) begin
                state_nxt         = S_NL;
                run_qualified_nxt = 1'b0;
              end
            end else begin
              if (run_length_r == '0) begin
                run_start_nxt = in_data.position;
              end
              load_vec[run_length_r[IDX_W-1:0]] = 1'b1;
              if (new_len >= m_eff) begin
                state_nxt         = S_REL;
                rel_cnt_nxt       = new_len;
                rel_first_nxt     = 1'b1;
                nl_pend_nxt       = in_data.end_of_range;
                run_qualified_nxt = !in_data.end_of_range;
                run_length_nxt    = '0;
              end else if (in_data.end_of_range) begin
                run_length_nxt = '0;
              end else begin
                run_length_nxt = new_len;
              end
            end
          end else begin
            if (run_qualified_r) begin
              emit                    = 1'b1;
              emit_item.out_byte      = NEWLINE_BYTE;
              emit_item.string_offset = run_start_r;
              emit_item.end_of_string = 1'b1;
              emit_item.last_of_step  = 1'b1;
            end
            run_qualified_nxt = 1'b0;
            run_length_nxt    = '0;
          end
        end
      end
      S_REL: begin
        if (out_free) begin
          // drain cell 0 and advance the row
          emit                      = 1'b1;
          emit_item.out_byte        = cell_bytes[0];
          emit_item.string_offset   = run_start_r;
          emit_item.first_of_string = rel_first_r;
          emit_item.last_of_step    = (rel_cnt_r == LEN_W'(1)) && !nl_pend_r;
          shift                     = 1'b1;
          rel_first_nxt             = 1'b0;
          rel_cnt_nxt               = rel_cnt_r - LEN_W'(1);
          if (rel_cnt_r == LEN_W'(1)) begin
            state_nxt = nl_pend_r ? S_NL : S_IDLE;
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_item.out_byte      = NEWLINE_BYTE;
          emit_item.string_offset = run_start_r;
          emit_item.end_of_string = 1'b1;
          emit_item.last_of_step  = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_item_nxt  = emit_item;
    end
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [BYTE_W-1:0] next_data;
    if (i == MAX_LEN - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_body
      assign next_data = cell_bytes[i+1];
    end
    pse_cell u_cell (
      .clk       (clk),
      .load      (load_vec[i]),
      .load_data (in_data.data_byte),
      .shift     (shift),
      .next_data (next_data),
      .cell_data (cell_bytes[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      min_len_r       <= MIN_LEN_RESET;
      run_length_r    <= '0;
      run_qualified_r <= 1'b0;
      run_start_r     <= '0;
      rel_cnt_r       <= '0;
      rel_first_r     <= 1'b0;
      nl_pend_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      run_length_r    <= run_length_nxt;
      run_qualified_r <= run_qualified_nxt;
      run_start_r     <= run_start_nxt;
      rel_cnt_r       <= rel_cnt_nxt;
      rel_first_r     <= rel_first_nxt;
      nl_pend_r       <= nl_pend_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        min_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  a_rel_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REL |-> rel_cnt_r != '0)
    else $error("release running with empty count");

  a_qual_empty: assert property (@(posedge clk) disable iff (!rst_n)
    run_qualified_r |-> run_length_r == '0)
    else $error("qualified run still holds bytes");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_length_r < LEN_W'(MAX_LEN))
    else $error("held run exceeds cell row");

  a_nl_closed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NL |-> !run_qualified_r && run_length_r == '0)
    else $error("newline pending on an open run");

  a_rel_drop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REL && out_free && rel_cnt_r == LEN_W'(1) && !nl_pend_r |=>
      state_r == S_IDLE && out_valid_r && out_data.last_of_step)
    else $error("release end not marked as last of step");

endmodule
